// ----- src/bfpf_pkg.sv -----
// ----------------------------------------------------------------------------
// bfpf_pkg: shared types and constants for the frame parser
// Sync codes, byte role codes and the per-beat result record.
// ----------------------------------------------------------------------------
package bfpf_pkg;

  // Frame sync pattern
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Role of a byte within a frame
  localparam logic [3:0] ROLE_NONE    = 4'd0;
  localparam logic [3:0] ROLE_SYNC1   = 4'd1;
  localparam logic [3:0] ROLE_SYNC2   = 4'd2;
  localparam logic [3:0] ROLE_CLASS   = 4'd3;
  localparam logic [3:0] ROLE_ID      = 4'd4;
  localparam logic [3:0] ROLE_LENLO   = 4'd5;
  localparam logic [3:0] ROLE_LENHI   = 4'd6;
  localparam logic [3:0] ROLE_PAYLOAD = 4'd7;
  localparam logic [3:0] ROLE_CKA     = 4'd8;
  localparam logic [3:0] ROLE_CKB     = 4'd9;

  // One result beat
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_role;
    logic        frame_end;
    logic        checksum_ok;
    logic        frame_accepted;
    logic        sync_error;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
  } result_t;

endpackage

// ----- src/bfpf_core.sv -----
// ----------------------------------------------------------------------------
// bfpf_core: frame tracking state and per-byte decode
// Holds the parse phase, Fletcher sums and frame fields; produces the
// result for the current byte and advances state when the byte is taken.
// ----------------------------------------------------------------------------
module bfpf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  input  logic              accept_bad_checksum,
  output bfpf_pkg::result_t result
);
  import bfpf_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENLO,
    PH_LENHI,
    PH_BODY,
    PH_CKB
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  class_reg, class_reg_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  received_sum_a, received_sum_a_next;

  // Running Fletcher update for the current byte
  logic [7:0] add_a, add_b;
  assign add_a = sum_a + rx_byte;
  assign add_b = sum_b + add_a;

  // Next state and result for this byte
  always_comb begin
    logic ok;
    ok                  = 1'b0;
    phase_next          = phase;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    bytes_left_next     = bytes_left;
    class_reg_next      = class_reg;
    id_reg_next         = id_reg;
    length_reg_next     = length_reg;
    received_sum_a_next = received_sum_a;

    result                = '0;
    result.byte_out       = rx_byte;
    result.byte_role      = ROLE_NONE;

    case (phase)
      PH_SYNC2: begin
        if (rx_byte == SYNC_SECOND) begin
          result.byte_role = ROLE_SYNC2;
          phase_next       = PH_CLASS;
        end else begin
          // Recheck the bad byte as a first sync byte
          result.sync_error = 1'b1;
          if (rx_byte == SYNC_FIRST) begin
            result.byte_role = ROLE_SYNC1;
            phase_next       = PH_SYNC2;
          end else begin
            phase_next = PH_SEARCH;
          end
        end
      end
      PH_CLASS: begin
        sum_a_next       = rx_byte;
        sum_b_next       = rx_byte;
        class_reg_next   = rx_byte;
        result.byte_role = ROLE_CLASS;
        phase_next       = PH_ID;
      end
      PH_ID: begin
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        id_reg_next      = rx_byte;
        result.byte_role = ROLE_ID;
        phase_next       = PH_LENLO;
      end
      PH_LENLO: begin
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        bytes_left_next  = {8'd0, rx_byte};
        result.byte_role = ROLE_LENLO;
        phase_next       = PH_LENHI;
      end
      PH_LENHI: begin
        sum_a_next       = add_a;
        sum_b_next       = add_b;
        bytes_left_next  = {rx_byte, bytes_left[7:0]};
        length_reg_next  = {rx_byte, bytes_left[7:0]};
        result.byte_role = ROLE_LENHI;
        phase_next       = PH_BODY;
      end
      PH_BODY: begin
        if (bytes_left != 16'd0) begin
          sum_a_next       = add_a;
          sum_b_next       = add_b;
          bytes_left_next  = bytes_left - 16'd1;
          result.byte_role = ROLE_PAYLOAD;
        end else begin
          received_sum_a_next = rx_byte;
          result.byte_role    = ROLE_CKA;
          phase_next          = PH_CKB;
        end
      end
      PH_CKB: begin
        ok                    = (received_sum_a == sum_a) && (rx_byte == sum_b);
        result.byte_role      = ROLE_CKB;
        result.frame_end      = 1'b1;
        result.checksum_ok    = ok;
        result.frame_accepted = ok | accept_bad_checksum;
        phase_next            = PH_SEARCH;
      end
      default: begin
        if (rx_byte == SYNC_FIRST) begin
          result.byte_role = ROLE_SYNC1;
          phase_next       = PH_SYNC2;
        end else begin
          phase_next = PH_SEARCH;
        end
      end
    endcase

    // Frame fields reflect the state after this byte
    result.msg_class   = class_reg_next;
    result.msg_id      = id_reg_next;
    result.payload_len = length_reg_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEARCH;
      sum_a          <= '0;
      sum_b          <= '0;
      bytes_left     <= '0;
      class_reg      <= '0;
      id_reg         <= '0;
      length_reg     <= '0;
      received_sum_a <= '0;
    end else if (take) begin
      phase          <= phase_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      bytes_left     <= bytes_left_next;
      class_reg      <= class_reg_next;
      id_reg         <= id_reg_next;
      length_reg     <= length_reg_next;
      received_sum_a <= received_sum_a_next;
    end
  end

endmodule

// ----- src/binary_frame_parser_fletcher8_unit.sv -----
// ----------------------------------------------------------------------------
// binary_frame_parser_fletcher8_unit: sync/class/id/length frame parser
// Tags each received byte with its frame role and checks the 8-bit
// Fletcher checksum at the end of every frame.
//
//   channel | handshake              | payload
//   --------+------------------------+---------------------------------------
//   input   | in_valid / in_stall    | rx_byte
//   output  | out_valid / out_stall  | byte_out .. payload_len
//   config  | cfg_valid / cfg_ready  | accept_bad_checksum
//
// One byte per cycle while in_stall is low; each result appears in the cycle after its byte is taken.
// Latency and rate are set by the single output register after the decode.
// While the output register holds a stalled beat, in_stall is raised unless
// the beat leaves in the same cycle.
// Synchronous reset returns the parser to sync search with sums cleared.
// ----------------------------------------------------------------------------
module binary_frame_parser_fletcher8_unit (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [3:0]  byte_role,
  output logic        frame_end,
  output logic        checksum_ok,
  output logic        frame_accepted,
  output logic        sync_error,
  output logic [7:0]  msg_class,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_len,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        accept_bad_checksum
);
  import bfpf_pkg::*;

  logic    bad_ck_en;
  logic    take;
  result_t step_res;
  result_t out_res;

  // Config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_ck_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bad_ck_en <= accept_bad_checksum;
    end
  end

  // Input handshake: take a beat when the output slot is free or draining
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  bfpf_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .take                (take),
    .rx_byte             (rx_byte),
    .accept_bad_checksum (bad_ck_en),
    .result              (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= step_res;
    end
  end

  assign byte_out       = out_res.byte_out;
  assign byte_role      = out_res.byte_role;
  assign frame_end      = out_res.frame_end;
  assign checksum_ok    = out_res.checksum_ok;
  assign frame_accepted = out_res.frame_accepted;
  assign sync_error     = out_res.sync_error;
  assign msg_class      = out_res.msg_class;
  assign msg_id         = out_res.msg_id;
  assign payload_len    = out_res.payload_len;

  // Checks
  a_end_on_ckb: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (byte_role == ROLE_CKB))
    else $error("frame_end on a byte that is not ck_b");

  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (checksum_ok || frame_accepted)) |-> frame_end)
    else $error("checksum status outside end of frame");

  a_ok_implies_acc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && checksum_ok) |-> frame_accepted)
    else $error("good checksum but frame not accepted");

  a_sync_err_role: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sync_error) |->
      ((byte_role == ROLE_NONE && byte_out != SYNC_FIRST) ||
       (byte_role == ROLE_SYNC1 && byte_out == SYNC_FIRST)))
    else $error("bad sync byte not rechecked as first sync");

  a_sync2_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_role == ROLE_SYNC2) |-> (byte_out == SYNC_SECOND))
    else $error("sync2 role on wrong byte");

endmodule

// ----- dv/tb_binary_frame_parser_fletcher8_unit.sv -----
// ----------------------------------------------------------------------------
// tb_binary_frame_parser_fletcher8_unit: self-checking bench for the parser
// Drives byte streams of good frames, checksum faults, broken sync pairs and
// line noise through the parser. Every output beat is compared field by
// field against a cycle-free frame tracker kept in the bench, under random
// gaps and stalls on both channels and under both override settings.
// ----------------------------------------------------------------------------
module tb_binary_frame_parser_fletcher8_unit;
  import bfpf_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;

  // Tracker phases while walking a frame
  typedef enum logic [3:0] {
    HUNT, WAIT_SYNC2, GET_CLASS, GET_ID, GET_LENLO, GET_LENHI, GET_BODY, GET_CKB
  } frame_phase_t;

  // Checksum damage applied when building a frame
  typedef enum int {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_fault_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  byte_out;
  logic [3:0]  byte_role;
  logic        frame_end;
  logic        checksum_ok;
  logic        frame_accepted;
  logic        sync_error;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_len;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        accept_bad_checksum = 1'b0;

  binary_frame_parser_fletcher8_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .byte_out       (byte_out),
    .byte_role      (byte_role),
    .frame_end      (frame_end),
    .checksum_ok    (checksum_ok),
    .frame_accepted (frame_accepted),
    .sync_error     (sync_error),
    .msg_class      (msg_class),
    .msg_id         (msg_id),
    .payload_len    (payload_len),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .accept_bad_checksum (accept_bad_checksum)
  );

  // Tracker state
  frame_phase_t trk_phase = HUNT;
  logic [7:0]   run_a = '0;
  logic [7:0]   run_b = '0;
  logic [15:0]  body_left = '0;
  logic [7:0]   cur_class = '0;
  logic [7:0]   cur_id = '0;
  logic [15:0]  cur_len = '0;
  logic [7:0]   got_cka = '0;
  logic         allow_bad_sum = 1'b0;

  result_t pending_tags[$];

  // Bench controls and counters
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic hold_req = 1'b0;
  logic [7:0] last_tx = 8'h00;
  int items_sent = 0;
  int beats_checked = 0;
  int error_count = 0;
  int frames_good = 0;
  int frames_bad = 0;
  int frames_taken = 0;
  int sync_errs = 0;
  int cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Tag one byte and advance the tracker
  function automatic result_t tag_rx_byte(logic [7:0] b);
    result_t r;
    logic resync;
    r = '0;
    r.byte_out = b;
    resync = 1'b0;
    case (trk_phase)
      WAIT_SYNC2: begin
        if (b == SYNC_SECOND) begin
          r.byte_role = ROLE_SYNC2;
          trk_phase = GET_CLASS;
        end else begin
          // broken pair: the byte may itself start a frame
          r.sync_error = 1'b1;
          resync = 1'b1;
        end
      end
      GET_CLASS: begin
        run_a = b;
        run_b = b;
        cur_class = b;
        r.byte_role = ROLE_CLASS;
        trk_phase = GET_ID;
      end
      GET_ID: begin
        run_a = run_a + b;
        run_b = run_b + run_a;
        cur_id = b;
        r.byte_role = ROLE_ID;
        trk_phase = GET_LENLO;
      end
      GET_LENLO: begin
        run_a = run_a + b;
        run_b = run_b + run_a;
        body_left = {8'h00, b};
        r.byte_role = ROLE_LENLO;
        trk_phase = GET_LENHI;
      end
      GET_LENHI: begin
        run_a = run_a + b;
        run_b = run_b + run_a;
        body_left = {b, body_left[7:0]};
        cur_len = body_left;
        r.byte_role = ROLE_LENHI;
        trk_phase = GET_BODY;
      end
      GET_BODY: begin
        if (body_left != 16'd0) begin
          run_a = run_a + b;
          run_b = run_b + run_a;
          body_left = body_left - 16'd1;
          r.byte_role = ROLE_PAYLOAD;
        end else begin
          got_cka = b;
          r.byte_role = ROLE_CKA;
          trk_phase = GET_CKB;
        end
      end
      GET_CKB: begin
        r.byte_role = ROLE_CKB;
        r.frame_end = 1'b1;
        r.checksum_ok = (got_cka == run_a) && (b == run_b);
        r.frame_accepted = r.checksum_ok || allow_bad_sum;
        trk_phase = HUNT;
      end
      default: resync = 1'b1;
    endcase
    if (resync) begin
      if (b == SYNC_FIRST) begin
        r.byte_role = ROLE_SYNC1;
        trk_phase = WAIT_SYNC2;
      end else begin
        r.byte_role = ROLE_NONE;
        trk_phase = HUNT;
      end
    end
    r.msg_class = cur_class;
    r.msg_id = cur_id;
    r.payload_len = cur_len;
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Payload length: mostly small, rarely past one length byte
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 8));
    if (r < 99) return 16'($urandom_range(9, 40));
    return 16'($urandom_range(256, 300));
  endfunction

  function automatic void check_field(string fld, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
      error_count++;
    end
  endfunction

  // Send one byte; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_tags.push_back(tag_rx_byte(b));
    last_tx = b;
    items_sent++;
  endtask

  // Let every expected beat come back, plus the output stage latency
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_override(input logic v);
    wait_drain();
    cfg_valid <= 1'b1;
    accept_bad_checksum <= v;
    do @(posedge clk); while (!cfg_ready);
    allow_bad_sum = v;
    cfg_valid <= 1'b0;
  endtask

  // Full frame with its own checksum, optionally damaged
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input ck_fault_t fault);
    logic [7:0] body[$];
    logic [7:0] fa, fb;
    body = {cls, id, len[7:0], len[15:8]};
    repeat (len) body.push_back(8'($urandom_range(0, 255)));
    fa = '0;
    fb = '0;
    foreach (body[i]) begin
      fa = fa + body[i];
      fb = fb + fa;
    end
    if (fault == CK_BAD_A) fa = fa ^ 8'($urandom_range(1, 255));
    if (fault == CK_BAD_B) fb = fb ^ 8'($urandom_range(1, 255));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (body[i]) send_byte(body[i]);
    send_byte(fa);
    send_byte(fb);
  endtask

  // Line noise that never forms a sync pair by itself
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (last_tx == SYNC_FIRST && b == SYNC_SECOND) b = 8'h00;
      send_byte(b);
    end
  endtask

  // First sync byte followed by anything but the second
  task automatic send_bad_sync();
    logic [7:0] b;
    send_byte(SYNC_FIRST);
    b = 8'($urandom_range(0, 254));
    if (b >= SYNC_SECOND) b = b + 8'd1;
    send_byte(b);
  endtask

  // Field extremes, every role, sync recovery, empty and short frames
  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_override(1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_frame(8'hFF, 8'h00, 16'd0, CK_GOOD);
    send_frame(8'h00, 8'hFF, 16'd2, CK_BAD_B);
    wait_drain();
  endtask

  // Override on and off around good and damaged frames
  task automatic test_override();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_override(1'b1);
    send_frame(8'h01, 8'h07, 16'd3, CK_GOOD);
    send_frame(8'h02, 8'h13, 16'd1, CK_BAD_A);
    send_frame(8'h06, 8'h8A, 16'd0, CK_BAD_B);
    send_noise(3);
    write_override(1'b0);
    send_frame(8'h05, 8'h01, 16'd4, CK_BAD_A);
    send_frame(8'h0A, 8'h04, 16'd2, CK_GOOD);
    wait_drain();
  endtask

  // Long receiver hold while the sender keeps offering bytes
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    wait_drain();
    hold_req = 1'b1;
    send_frame(8'h0B, 8'h30, 16'd20, CK_GOOD);
    wait (!hold_req);
    // sender pauses until every beat is back
    wait_drain();
    rx_idle_en = 1'b1;
    send_frame(8'h0D, 8'h01, 16'd12, CK_GOOD);
    send_bad_sync();
    send_frame(8'h27, 8'h02, 16'd6, CK_BAD_A);
    wait_drain();
  endtask

  // Mostly well-formed frames with random content, plus noise and bad syncs
  task automatic test_random_stream();
    int r;
    int seg_end;
    while (items_sent < ITEM_TARGET) begin
      write_override(1'($urandom_range(0, 1)));
      r = $urandom_range(0, 3);
      tx_idle_en = (r == 0 || r == 1);
      rx_idle_en = (r == 0 || r == 2);
      seg_end = items_sent + $urandom_range(100, 250);
      while (items_sent < seg_end && items_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          r = $urandom_range(0, 99);
          send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_len(),
                     (r < 8) ? CK_BAD_A : (r < 15) ? CK_BAD_B : CK_GOOD);
        end else if (r < 85) begin
          send_noise($urandom_range(1, 6));
        end else begin
          send_bad_sync();
        end
      end
    end
    wait_drain();
  endtask

  // Receiver stall pattern; a hold request wins over random stalls
  initial begin : rx_stall_gen
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (rx_idle_en ? $urandom_range(1, 6) : 1) @(posedge clk);
      end
    end
  end

  // Compare each delivered beat with the oldest expected tag
  always @(posedge clk) begin : tag_checker
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {byte_out, byte_role, frame_end, checksum_ok, frame_accepted, sync_error,
             msg_class, msg_id, payload_len};
      beats_checked++;
      if (got.frame_end) begin
        if (got.checksum_ok) frames_good++;
        else frames_bad++;
        if (got.frame_accepted) frames_taken++;
      end
      if (got.sync_error) sync_errs++;
      if (pending_tags.size() == 0) begin
        $display("%0t: beat with nothing expected: expected none, actual byte %0h role %0d",
                 $time, got.byte_out, got.byte_role);
        error_count++;
      end else begin
        want = pending_tags.pop_front();
        check_field("byte_out", 16'(want.byte_out), 16'(got.byte_out));
        check_field("byte_role", 16'(want.byte_role), 16'(got.byte_role));
        check_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
        check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
        check_field("frame_accepted", 16'(want.frame_accepted), 16'(got.frame_accepted));
        check_field("sync_error", 16'(want.sync_error), 16'(got.sync_error));
        check_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
        check_field("msg_id", 16'(want.msg_id), 16'(got.msg_id));
        check_field("payload_len", want.payload_len, got.payload_len);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding",
               $time, cycle_count, pending_tags.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_override();
    test_backpressure();
    test_random_stream();
    repeat (8) @(posedge clk);
    if (pending_tags.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, pending_tags.size());
      error_count++;
    end
    $display("Sent %0d bytes, checked %0d beats, %0d mismatches", items_sent,
             beats_checked, error_count);
    $display("Frames: %0d checksum good, %0d bad, %0d accepted; %0d sync errors",
             frames_good, frames_bad, frames_taken, sync_errs);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bfpf_pkg.sv
src/bfpf_core.sv
src/binary_frame_parser_fletcher8_unit.sv
dv/tb_binary_frame_parser_fletcher8_unit.sv
